// File: sv/affra_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// affra_pkg
// Shared types and codes for the aligned first-fit range allocator.
// ---------------------------------------------------------------------------
package affra_pkg;

	localparam int ENTRY_W = 36;
	localparam int FIELD_W = 48;
	localparam int ST_W    = 3;

	// request commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD     = 3'd1;
	localparam logic [ST_W-1:0] ST_NOFIT   = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
	localparam logic [ST_W-1:0] ST_OUTSIDE = 3'd4;

	// configuration register indexes
	localparam logic REG_BASE_PAGE = 1'b0;
	localparam logic REG_PAGES     = 1'b1;

	typedef struct packed {
		logic               command;
		logic [FIELD_W-1:0] size_bytes;
		logic [FIELD_W-1:0] align_bytes;
		logic [FIELD_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] address;
		logic [ST_W-1:0]    status;
	} rsp_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] start;
		logic [ENTRY_W-1:0] len;
	} entry_t;

	typedef enum logic [21:0] {
		S_IDLE = 22'h000001,
		S_INIT = 22'h000002,
		S_CHK1 = 22'h000004,
		S_CHK2 = 22'h000008,
		S_CHK3 = 22'h000010,
		S_RD   = 22'h000020,
		S_E1   = 22'h000040,
		S_E2   = 22'h000080,
		S_E3   = 22'h000100,
		S_E4   = 22'h000200,
		S_E5   = 22'h000400,
		S_ADEC = 22'h000800,
		S_FS   = 22'h001000,
		S_F1   = 22'h002000,
		S_F2   = 22'h004000,
		S_FDEC = 22'h008000,
		S_SHCK = 22'h010000,
		S_SHRD = 22'h020000,
		S_SHWR = 22'h040000,
		S_WR1  = 22'h080000,
		S_WR2  = 22'h100000,
		S_DONE = 22'h200000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic init;
		logic chk1;
		logic chk2;
		logic chk3;
		logic rd;
		logic e1;
		logic e2;
		logic e3;
		logic e4;
		logic e5;
		logic adec;
		logic fs;
		logic f1;
		logic f2;
		logic fdec;
		logic shrd;
		logic shwr;
		logic wr1;
		logic wr2;
		logic done;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_init;
		logic is_free;
		logic reject_done;
		logic free_empty;
		logic fit;
		logic scan_last;
		logic adec_full;
		logic fs_below;
		logic fdec_full;
		logic sh_more;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: sv/aligned_first_fit_range_allocator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// aligned_first_fit_range_allocator
// Page-granular first-fit allocator over a reserved region, with coalescing.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries allocate or free requests; rsp channel
//   (valid/ready) returns one result per request: address and status.
//   APB port at byte 0 (region base page) and byte 8 (region page count);
//   write only while no request is in flight.
// Flow: the free-range table sits in a single-port-read RAM, so every
//   visited entry costs a read. Allocate reads each entry and runs the fit
//   test on it until one fits; free reads entries to find its slot and
//   tests the merges; an insert or remove then shifts each later entry,
//   and the writes and the result follow. One request is in work at a time.
// Reset: the table is empty; the first request, of either kind, builds it
//   from the current registers in the INIT state. No clearing pass.
// Stall: the result waits in an output register; a new request is taken
//   while it waits, and the block holds its next result until it is taken.
// ---------------------------------------------------------------------------
module aligned_first_fit_range_allocator #(
	parameter int PAGE_BYTES   = 4096,
	parameter int MAX_RANGES   = 64,
	parameter int ADDRESS_BITS = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire affra_pkg::req_t  req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output affra_pkg::rsp_t       rsp,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [3:0]       paddr,
	input  wire logic [63:0]      pwdata,
	output logic      [63:0]      prdata,
	output logic                  pready
);
	import affra_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	assign pready = 1'b1;

	// sequencer
	affra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and arithmetic
	affra_dp #(
		.PAGE_BYTES   (PAGE_BYTES),
		.MAX_RANGES   (MAX_RANGES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata)
	);
endmodule
`default_nettype wire

// File: sv/affra_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// affra_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module affra_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: sv/affra_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// affra_ctrl
// Sequencer: walks each request through check, scan, shift and write steps.
// ---------------------------------------------------------------------------
module affra_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire affra_pkg::dp_sts_t sts,
	output affra_pkg::ctl_cmd_t     cmd
);
	import affra_pkg::*;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = sts.need_init ? S_INIT : S_CHK1;
			S_INIT: state_d = S_CHK1;
			S_CHK1: state_d = S_CHK2;
			S_CHK2: state_d = S_CHK3;
			S_CHK3: begin
				priority if (sts.reject_done) state_d = S_DONE;
				else if (sts.free_empty) state_d = S_F1;
				else state_d = S_RD;
			end
			S_RD:   state_d = sts.is_free ? S_FS : S_E1;
			S_E1:   state_d = S_E2;
			S_E2:   state_d = S_E3;
			S_E3:   state_d = S_E4;
			S_E4:   state_d = S_E5;
			S_E5:   state_d = S_ADEC;
			S_ADEC: begin
				priority if (!sts.fit) state_d = sts.scan_last ? S_DONE : S_RD;
				else if (sts.adec_full) state_d = S_DONE;
				else state_d = S_SHCK;
			end
			S_FS: begin
				if (sts.fs_below && !sts.scan_last) state_d = S_RD;
				else state_d = S_F1;
			end
			S_F1:   state_d = S_F2;
			S_F2:   state_d = S_FDEC;
			S_FDEC: state_d = sts.fdec_full ? S_DONE : S_SHCK;
			S_SHCK: state_d = sts.sh_more ? S_SHRD : S_WR1;
			S_SHRD: state_d = S_SHWR;
			S_SHWR: state_d = S_SHCK;
			S_WR1:  state_d = S_WR2;
			S_WR2:  state_d = S_DONE;
			S_DONE: if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command decode
	assign req_ready  = (state_q == S_IDLE);
	assign cmd.accept = (state_q == S_IDLE) && req_valid;
	assign cmd.init   = (state_q == S_INIT);
	assign cmd.chk1   = (state_q == S_CHK1);
	assign cmd.chk2   = (state_q == S_CHK2);
	assign cmd.chk3   = (state_q == S_CHK3);
	assign cmd.rd     = (state_q == S_RD);
	assign cmd.e1     = (state_q == S_E1);
	assign cmd.e2     = (state_q == S_E2);
	assign cmd.e3     = (state_q == S_E3);
	assign cmd.e4     = (state_q == S_E4);
	assign cmd.e5     = (state_q == S_E5);
	assign cmd.adec   = (state_q == S_ADEC);
	assign cmd.fs     = (state_q == S_FS);
	assign cmd.f1     = (state_q == S_F1);
	assign cmd.f2     = (state_q == S_F2);
	assign cmd.fdec   = (state_q == S_FDEC);
	assign cmd.shrd   = (state_q == S_SHRD);
	assign cmd.shwr   = (state_q == S_SHWR);
	assign cmd.wr1    = (state_q == S_WR1);
	assign cmd.wr2    = (state_q == S_WR2);
	assign cmd.done   = (state_q == S_DONE);
endmodule
`default_nettype wire

// File: sv/affra_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// affra_dp
// Datapath: config registers, range table, fit and merge arithmetic, result.
// ---------------------------------------------------------------------------
module affra_dp #(
	parameter int PAGE_BYTES   = 4096,
	parameter int MAX_RANGES   = 64,
	parameter int ADDRESS_BITS = 48
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire affra_pkg::ctl_cmd_t cmd,
	output affra_pkg::dp_sts_t       sts,
	input  wire affra_pkg::req_t     req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output affra_pkg::rsp_t          rsp,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [63:0]         pwdata,
	output logic      [63:0]         prdata
);
	import affra_pkg::*;

	localparam int PS  = $clog2(PAGE_BYTES);
	localparam int BW  = ((37 + PS > 49) ? 37 + PS : 49) + 1;
	localparam int NW  = BW - PS + 1;
	localparam int IW  = $clog2(MAX_RANGES);
	localparam int CW  = $clog2(MAX_RANGES + 1);
	localparam int MB  = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
	localparam int EW  = 2 * ENTRY_W;
	localparam logic [FIELD_W-1:0] AMASK = (FIELD_W'(1) << MB) - FIELD_W'(1);
	localparam logic [36:0] LIMIT36 = 37'h1000000000;

	// configuration registers
	logic [35:0] base_page_q;
	logic [36:0] region_pages_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_page_q    <= 36'd1;
			region_pages_q <= 37'd1048576;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3])
				REG_BASE_PAGE: base_page_q    <= pwdata[35:0];
				REG_PAGES:     region_pages_q <= pwdata[36:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_BASE_PAGE: prdata = {28'd0, base_page_q};
			REG_PAGES:     prdata = {27'd0, region_pages_q};
			default:       prdata = '0;
		endcase
	end

	logic [36:0]   live_pages;
	logic [BW-1:0] base_bytes;
	assign live_pages = (region_pages_q > LIMIT36) ? LIMIT36 : region_pages_q;
	assign base_bytes = BW'(base_page_q) << PS;

	// range table
	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	entry_t        ram_wdata, ram_rdata;
	logic [EW-1:0] ram_rbits;
	assign ram_rdata = entry_t'(ram_rbits);

	affra_ram #(.WIDTH(EW), .DEPTH(MAX_RANGES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (EW'(ram_wdata)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);

	// control registers
	logic          ready_q;
	logic [CW-1:0] count_q;
	logic          out_valid_q;

	// request and working registers
	req_t          req_q;
	logic [NW-1:0] pages_q;
	logic [47:0]   alm1_q;
	logic          bad_q, below_q;
	logic [47:0]   diff_q;
	logic [NW-1:0] off_q;
	logic [CW-1:0] idx_q;
	entry_t        cur_q, prev_q;
	logic          has_cur_q, has_prev_q;
	logic [BW-1:0] a_q, aligned_q;
	logic [NW-1:0] prefix_q, need_q, suffix_q;
	logic [35:0]   newstart_q;
	logic          fit_q;
	logic          c1_q, c2_q, c3_q;
	logic [35:0]   nl_q, nl2_q, nl3_q;
	rsp_t          res_q, rsp_q;

	// shift and write plan
	logic          sh_act_q, sh_open_q;
	logic [CW-1:0] k_q, t_q;
	logic          w1v_q, w2v_q;
	logic [IW-1:0] w1a_q, w2a_q;
	entry_t        w1d_q, w2d_q;
	logic          inc_q, dec_q;

	// combinational helpers
	logic [48:0]     size_up;
	logic [47:0]     al;
	logic            count_full, scan_last;
	logic [CW-1:0]   sh_src;
	logic            pfx_nz, sfx_nz;
	logic [NW-1:0]   lim_n;
	logic [ST_W-1:0] verdict;

	assign size_up    = {1'b0, req_q.size_bytes} + 49'(PAGE_BYTES - 1);
	assign al         = (req_q.align_bytes < 48'(PAGE_BYTES)) ? 48'(PAGE_BYTES)
	                                                          : req_q.align_bytes;
	assign count_full = (count_q >= CW'(MAX_RANGES));
	assign scan_last  = ((idx_q + CW'(1)) >= count_q);
	assign sh_src     = sh_open_q ? (k_q - CW'(1)) : (k_q + CW'(1));
	assign pfx_nz     = (prefix_q != '0);
	assign sfx_nz     = (suffix_q != '0);
	assign lim_n      = NW'(live_pages);

	// verdict of the request checks, ahead of the scan
	always_comb begin
		priority if (bad_q) begin
			verdict = ST_BAD;
		end else if (req_q.command == CMD_FREE && (below_q || off_q >= lim_n ||
		             pages_q > (lim_n - off_q))) begin
			verdict = ST_OUTSIDE;
		end else if (req_q.command == CMD_ALLOC && count_q == '0) begin
			verdict = ST_NOFIT;
		end else begin
			verdict = ST_OK;
		end
	end

	// status to the controller
	assign sts.need_init   = !ready_q;
	assign sts.is_free     = (req_q.command == CMD_FREE);
	assign sts.reject_done = (verdict != ST_OK);
	assign sts.free_empty  = (req_q.command == CMD_FREE) && (count_q == '0);
	assign sts.fit         = fit_q;
	assign sts.scan_last   = scan_last;
	assign sts.adec_full   = pfx_nz && sfx_nz && count_full;
	assign sts.fs_below    = (NW'(ram_rdata.start) < off_q);
	assign sts.fdec_full   = !c1_q && !c3_q && count_full;
	assign sts.sh_more     = sh_act_q && (sh_open_q ? (k_q > t_q)
	                                                 : ((k_q + CW'(1)) < count_q));
	assign sts.out_free    = !out_valid_q || rsp_ready;

	// table ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = cmd.rd || cmd.shrd;
		ram_raddr = cmd.shrd ? sh_src[IW-1:0] : idx_q[IW-1:0];
		priority if (cmd.init) begin
			ram_we          = 1'b1;
			ram_wdata.start = 36'd1;
			ram_wdata.len   = live_pages[35:0] - 36'd1;
		end else if (cmd.shwr) begin
			ram_we    = 1'b1;
			ram_waddr = k_q[IW-1:0];
			ram_wdata = ram_rdata;
		end else if (cmd.wr1) begin
			ram_we    = w1v_q;
			ram_waddr = w1a_q;
			ram_wdata = w1d_q;
		end else if (cmd.wr2) begin
			ram_we    = w2v_q;
			ram_waddr = w2a_q;
			ram_wdata = w2d_q;
		end else begin
			ram_we = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				ready_q <= 1'b1;
				count_q <= (live_pages >= 37'd2) ? CW'(1) : CW'(0);
			end
			if (cmd.done && (!out_valid_q || rsp_ready)) begin
				out_valid_q <= 1'b1;
				count_q     <= count_q + CW'(inc_q) - CW'(dec_q);
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end

		// request checks, stage one
		if (cmd.chk1) begin
			pages_q <= NW'(size_up >> PS);
			alm1_q  <= al - 48'd1;
			diff_q  <= req_q.free_address - base_bytes[47:0];
			below_q <= (BW'(req_q.free_address) < base_bytes);
			if (req_q.command == CMD_FREE) begin
				bad_q <= (req_q.size_bytes == '0) ||
				         (req_q.free_address[PS-1:0] != '0);
			end else begin
				bad_q <= (req_q.size_bytes == '0) || ((al & (al - 48'd1)) != '0);
			end
		end

		if (cmd.chk2) begin
			off_q <= NW'(diff_q >> PS);
		end

		// final verdict before the scan
		if (cmd.chk3) begin
			res_q.address <= '0;
			res_q.status  <= verdict;
			idx_q      <= '0;
			has_cur_q  <= 1'b0;
			has_prev_q <= 1'b0;
			sh_act_q   <= 1'b0;
			sh_open_q  <= 1'b0;
			w1v_q      <= 1'b0;
			w2v_q      <= 1'b0;
			inc_q      <= 1'b0;
			dec_q      <= 1'b0;
		end

		// allocate: fit test on one entry
		if (cmd.e1) begin
			cur_q <= ram_rdata;
			a_q   <= base_bytes + (BW'(ram_rdata.start) << PS);
		end
		if (cmd.e2) begin
			aligned_q <= (a_q + BW'(alm1_q)) & ~BW'(alm1_q);
		end
		if (cmd.e3) begin
			prefix_q <= NW'((aligned_q - a_q) >> PS);
		end
		if (cmd.e4) begin
			need_q <= prefix_q + pages_q;
		end
		if (cmd.e5) begin
			fit_q      <= (need_q <= NW'(cur_q.len));
			suffix_q   <= NW'(cur_q.len) - need_q;
			newstart_q <= cur_q.start + need_q[35:0];
		end

		// allocate: take the range or move on
		if (cmd.adec) begin
			if (!fit_q) begin
				idx_q <= idx_q + CW'(1);
				if (scan_last) begin
					res_q.status <= ST_NOFIT;
				end
			end else if (pfx_nz && sfx_nz) begin
				if (count_full) begin
					res_q.status <= ST_FULL;
				end else begin
					res_q.address   <= aligned_q[47:0] & AMASK;
					sh_act_q        <= 1'b1;
					sh_open_q       <= 1'b1;
					k_q             <= count_q;
					t_q             <= idx_q + CW'(1);
					w1v_q           <= 1'b1;
					w1a_q           <= idx_q[IW-1:0];
					w1d_q.start     <= cur_q.start;
					w1d_q.len       <= prefix_q[35:0];
					w2v_q           <= 1'b1;
					w2a_q           <= IW'(idx_q + CW'(1));
					w2d_q.start     <= newstart_q;
					w2d_q.len       <= suffix_q[35:0];
					inc_q           <= 1'b1;
				end
			end else begin
				res_q.address <= aligned_q[47:0] & AMASK;
				if (pfx_nz) begin
					w1v_q       <= 1'b1;
					w1a_q       <= idx_q[IW-1:0];
					w1d_q.start <= cur_q.start;
					w1d_q.len   <= prefix_q[35:0];
				end else if (sfx_nz) begin
					w1v_q       <= 1'b1;
					w1a_q       <= idx_q[IW-1:0];
					w1d_q.start <= newstart_q;
					w1d_q.len   <= suffix_q[35:0];
				end else begin
					sh_act_q  <= 1'b1;
					sh_open_q <= 1'b0;
					k_q       <= idx_q;
					dec_q     <= 1'b1;
				end
			end
		end

		// free: find the insertion point
		if (cmd.fs) begin
			if (NW'(ram_rdata.start) < off_q) begin
				prev_q     <= ram_rdata;
				has_prev_q <= 1'b1;
				idx_q      <= idx_q + CW'(1);
			end else begin
				cur_q     <= ram_rdata;
				has_cur_q <= 1'b1;
			end
		end

		// free: neighbor merge tests
		if (cmd.f1) begin
			c1_q <= has_prev_q &&
			        (NW'({1'b0, prev_q.start} + {1'b0, prev_q.len}) == off_q);
			nl_q <= prev_q.len + pages_q[35:0];
		end
		if (cmd.f2) begin
			c2_q  <= has_cur_q && ({1'b0, prev_q.start} + {1'b0, nl_q} ==
			                       {1'b0, cur_q.start});
			nl2_q <= nl_q + cur_q.len;
			c3_q  <= has_cur_q && (off_q + pages_q == NW'(cur_q.start));
			nl3_q <= cur_q.len + pages_q[35:0];
		end

		// free: choose merge, extend or insert, or report a full table
		if (cmd.fdec) begin
			priority if (c1_q) begin
				w1v_q       <= 1'b1;
				w1a_q       <= IW'(idx_q - CW'(1));
				w1d_q.start <= prev_q.start;
				w1d_q.len   <= c2_q ? nl2_q : nl_q;
				if (c2_q) begin
					sh_act_q  <= 1'b1;
					sh_open_q <= 1'b0;
					k_q       <= idx_q;
					dec_q     <= 1'b1;
				end
			end else if (c3_q) begin
				w1v_q       <= 1'b1;
				w1a_q       <= idx_q[IW-1:0];
				w1d_q.start <= off_q[35:0];
				w1d_q.len   <= nl3_q;
			end else if (count_full) begin
				res_q.status <= ST_FULL;
			end else begin
				sh_act_q    <= 1'b1;
				sh_open_q   <= 1'b1;
				k_q         <= count_q;
				t_q         <= idx_q;
				w1v_q       <= 1'b1;
				w1a_q       <= idx_q[IW-1:0];
				w1d_q.start <= off_q[35:0];
				w1d_q.len   <= pages_q[35:0];
				inc_q       <= 1'b1;
			end
		end

		// shift: step the entry index after each entry is moved
		if (cmd.shwr) begin
			k_q <= sh_open_q ? (k_q - CW'(1)) : (k_q + CW'(1));
		end

		if (cmd.done && (!out_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire
